### rtl/euler_rotation_3d_unit_assert.svh
// ---------------------------------------------------------------------------
// euler_rotation_3d_unit assertion macros
// Concurrent checks for the rotation unit, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef EULER_ROTATION_3D_UNIT_ASSERT_SVH
`define EULER_ROTATION_3D_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define EUL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define EUL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EUL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define EUL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/eul_pkg.sv
// ---------------------------------------------------------------------------
// eul_pkg
// Shared types, constants and the Q2.30 multiply for the rotation unit.
// ---------------------------------------------------------------------------
package eul_pkg;

    // series terms of the quarter-wave sine
    localparam int TAYLOR_STEPS = 6;
    localparam int unsigned TAYLOR_DIV [TAYLOR_STEPS] = '{156, 110, 72, 42, 20, 6};

    // Q2.30 constants
    localparam logic [30:0] Q_ONE      = 31'h4000_0000;
    localparam logic [63:0] Q_HALF     = 64'h0000_0000_2000_0000;
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;

    // pipeline depths
    localparam int SINE_LAT   = 5 + 3 * TAYLOR_STEPS;
    localparam int MATRIX_LAT = 3;
    localparam int ROW_LAT    = 4;

    // sine/cosine value, Q2.30 in [-1, 1]
    typedef logic signed [31:0] t_trig;

    typedef struct packed {
        t_trig sx;
        t_trig cx;
        t_trig sy;
        t_trig cy;
        t_trig sz;
        t_trig cz;
    } t_trig_set;

    // matrix coefficient, Q3.30 with headroom for a sum of two terms
    typedef logic signed [32:0] t_coef;
    // row-major, entry r*3+c
    typedef t_coef [8:0] t_matrix;

    // Q2.30 product, rounded half up
    function automatic t_trig qmul(input t_trig a, input t_trig b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] p;
        wa = a;
        wb = b;
        p  = wa * wb + $signed(Q_HALF);
        return p[61:30];
    endfunction

endpackage

### rtl/eul_if.sv
// ---------------------------------------------------------------------------
// eul_in_if / eul_out_if
// Valid/ready channels carrying one point in and one rotated point out.
// ---------------------------------------------------------------------------
interface eul_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;
    logic [ANGLE_WIDTH-1:0]        angle_x;
    logic [ANGLE_WIDTH-1:0]        angle_y;
    logic [ANGLE_WIDTH-1:0]        angle_z;

    modport source (output valid, action, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                    input ready);
    modport sink   (input valid, action, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                    output ready);
endinterface

interface eul_out_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          clipped;

    modport source (output valid, out_x, out_y, out_z, clipped, input ready);
    modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

### rtl/eul_sine.sv
// ---------------------------------------------------------------------------
// eul_sine
// Pipelined sine of a 32-bit phase: quadrant fold, series in Horner form
// with one stage triple per term, rounding and sign restore.
// ---------------------------------------------------------------------------
module eul_sine (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [31:0]    i_phase,
    output eul_pkg::t_trig o_sine
);
    localparam int STEPS = eul_pkg::TAYLOR_STEPS;
    localparam int NEG_W = eul_pkg::SINE_LAT - 1;

    // quadrant fold
    logic [30:0]      r_u;
    logic [NEG_W-1:0] r_neg;
    logic [30:0]      n_u;

    always_comb begin
        if (i_phase[30]) begin
            n_u = eul_pkg::Q_ONE - {1'b0, i_phase[29:0]};
        end else begin
            n_u = {1'b0, i_phase[29:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u   <= n_u;
            r_neg <= {r_neg[NEG_W-2:0], i_phase[31]};
        end
    end

    // theta = u * pi/2
    logic [63:0] w_th_p;
    logic [30:0] r_theta;
    assign w_th_p = {33'b0, r_u} * {33'b0, eul_pkg::HALFPI_Q30} + eul_pkg::Q_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_theta <= w_th_p[60:30];
        end
    end

    // theta squared
    logic [63:0] w_t2_p;
    logic [31:0] r_t2;
    logic [30:0] r_th3;
    assign w_t2_p = {33'b0, r_theta} * {33'b0, r_theta} + eul_pkg::Q_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t2  <= w_t2_p[61:30];
            r_th3 <= r_theta;
        end
    end

    // series terms, three stages each
    logic [30:0] it_r  [STEPS+1];
    logic [30:0] it_th [STEPS+1];
    logic [31:0] it_t2 [STEPS];

    logic [31:0] r_ax  [STEPS];
    logic [31:0] r_at2 [STEPS];
    logic [30:0] r_ath [STEPS];
    logic [31:0] r_bq  [STEPS];
    logic [31:0] r_bx  [STEPS];
    logic [31:0] r_bt2 [STEPS];
    logic [30:0] r_bth [STEPS];
    logic [30:0] r_cr  [STEPS];
    logic [30:0] r_cth [STEPS];

    assign it_r[0]  = eul_pkg::Q_ONE;
    assign it_th[0] = r_th3;
    assign it_t2[0] = r_t2;

    for (genvar g = 0; g < STEPS; g++) begin : g_term
        localparam int unsigned K     = eul_pkg::TAYLOR_DIV[g];
        localparam int          SH    = 32 + $clog2(K);
        localparam logic [32:0] RECIP = 33'((65'd1 << SH) / K);

        logic [63:0] w_xp;
        logic [64:0] w_qp;
        logic [39:0] w_rem;
        logic [31:0] w_q;

        // t2 * r, rounded
        assign w_xp = {32'b0, it_t2[g]} * {33'b0, it_r[g]} + eul_pkg::Q_HALF;

        // quotient estimate by reciprocal, low by at most one
        assign w_qp = 65'(r_ax[g]) * 65'(RECIP);

        // one correction step
        assign w_rem = 40'(r_bx[g]) - 40'(r_bq[g]) * 40'(K);
        assign w_q   = (w_rem >= 40'(K)) ? r_bq[g] + 32'd1 : r_bq[g];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ax[g]  <= w_xp[61:30];
                r_at2[g] <= it_t2[g];
                r_ath[g] <= it_th[g];
                r_bq[g]  <= 32'(w_qp >> SH);
                r_bx[g]  <= r_ax[g];
                r_bt2[g] <= r_at2[g];
                r_bth[g] <= r_ath[g];
                r_cr[g]  <= eul_pkg::Q_ONE - w_q[30:0];
                r_cth[g] <= r_bth[g];
            end
        end

        assign it_r[g+1]  = r_cr[g];
        assign it_th[g+1] = r_cth[g];
        if (g < STEPS - 1) begin : g_t2
            logic [31:0] r_ct2;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ct2 <= r_bt2[g];
                end
            end
            assign it_t2[g+1] = r_ct2;
        end
    end

    // theta * r, rounded
    logic [63:0] w_s_p;
    logic [31:0] r_s;
    assign w_s_p = {33'b0, it_th[STEPS]} * {33'b0, it_r[STEPS]} + eul_pkg::Q_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= w_s_p[61:30];
        end
    end

    // clamp to one, restore sign
    logic [31:0]    w_sc;
    eul_pkg::t_trig r_out;
    assign w_sc = (r_s > {1'b0, eul_pkg::Q_ONE}) ? {1'b0, eul_pkg::Q_ONE} : r_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_neg[NEG_W-1] ? -$signed(w_sc) : $signed(w_sc);
        end
    end

    assign o_sine = r_out;

endmodule

### rtl/eul_matrix.sv
// ---------------------------------------------------------------------------
// eul_matrix
// Builds the 3x3 rotation matrix from the six sines and cosines: pair
// products, triple products, then the per-mode sums.
// ---------------------------------------------------------------------------
module eul_matrix (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_action,
    input  eul_pkg::t_trig_set i_trig,
    output eul_pkg::t_matrix   o_coef
);
    // pair products
    eul_pkg::t_trig r_cycz, r_cysz, r_czsx, r_cxsz, r_cxcz;
    eul_pkg::t_trig r_sxsy, r_cysx, r_sxsz, r_cxcy, r_cxsy;
    eul_pkg::t_trig r1_sy, r1_sz;
    logic           r1_act;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= eul_pkg::qmul(i_trig.cy, i_trig.cz);
            r_cysz <= eul_pkg::qmul(i_trig.cy, i_trig.sz);
            r_czsx <= eul_pkg::qmul(i_trig.cz, i_trig.sx);
            r_cxsz <= eul_pkg::qmul(i_trig.cx, i_trig.sz);
            r_cxcz <= eul_pkg::qmul(i_trig.cx, i_trig.cz);
            r_sxsy <= eul_pkg::qmul(i_trig.sx, i_trig.sy);
            r_cysx <= eul_pkg::qmul(i_trig.cy, i_trig.sx);
            r_sxsz <= eul_pkg::qmul(i_trig.sx, i_trig.sz);
            r_cxcy <= eul_pkg::qmul(i_trig.cx, i_trig.cy);
            r_cxsy <= eul_pkg::qmul(i_trig.cx, i_trig.sy);
            r1_sy  <= i_trig.sy;
            r1_sz  <= i_trig.sz;
            r1_act <= i_action;
        end
    end

    // triple products, pairs passed along
    eul_pkg::t_trig r_czsxsy, r_cxczsy, r_sxsysz, r_cxsysz;
    eul_pkg::t_trig r2_cycz, r2_cysz, r2_czsx, r2_cxsz, r2_cxcz;
    eul_pkg::t_trig r2_cysx, r2_sxsz, r2_cxcy, r2_sy;
    logic           r2_act;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_czsxsy <= eul_pkg::qmul(r_czsx, r1_sy);
            r_cxczsy <= eul_pkg::qmul(r_cxcz, r1_sy);
            r_sxsysz <= eul_pkg::qmul(r_sxsy, r1_sz);
            r_cxsysz <= eul_pkg::qmul(r_cxsy, r1_sz);
            r2_cycz  <= r_cycz;
            r2_cysz  <= r_cysz;
            r2_czsx  <= r_czsx;
            r2_cxsz  <= r_cxsz;
            r2_cxcz  <= r_cxcz;
            r2_cysx  <= r_cysx;
            r2_sxsz  <= r_sxsz;
            r2_cxcy  <= r_cxcy;
            r2_sy    <= r1_sy;
            r2_act   <= r1_act;
        end
    end

    // per-mode sums
    eul_pkg::t_matrix n_coef;
    eul_pkg::t_matrix r_coef;

    always_comb begin
        n_coef[0] = eul_pkg::t_coef'(r2_cycz);
        n_coef[8] = eul_pkg::t_coef'(r2_cxcy);
        if (r2_act) begin
            // z-y-x order
            n_coef[1] = eul_pkg::t_coef'(r_czsxsy) - eul_pkg::t_coef'(r2_cxsz);
            n_coef[2] = eul_pkg::t_coef'(r_cxczsy) + eul_pkg::t_coef'(r2_sxsz);
            n_coef[3] = eul_pkg::t_coef'(r2_cysz);
            n_coef[4] = eul_pkg::t_coef'(r2_cxcz) + eul_pkg::t_coef'(r_sxsysz);
            n_coef[5] = eul_pkg::t_coef'(r_cxsysz) - eul_pkg::t_coef'(r2_czsx);
            n_coef[6] = -eul_pkg::t_coef'(r2_sy);
            n_coef[7] = eul_pkg::t_coef'(r2_cysx);
        end else begin
            // x-y-z order
            n_coef[1] = -eul_pkg::t_coef'(r2_cysz);
            n_coef[2] = eul_pkg::t_coef'(r2_sy);
            n_coef[3] = eul_pkg::t_coef'(r_czsxsy) + eul_pkg::t_coef'(r2_cxsz);
            n_coef[4] = eul_pkg::t_coef'(r2_cxcz) - eul_pkg::t_coef'(r_sxsysz);
            n_coef[5] = -eul_pkg::t_coef'(r2_cysx);
            n_coef[6] = eul_pkg::t_coef'(r2_sxsz) - eul_pkg::t_coef'(r_cxczsy);
            n_coef[7] = eul_pkg::t_coef'(r2_czsx) + eul_pkg::t_coef'(r_cxsysz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coef <= n_coef;
        end
    end

    assign o_coef = r_coef;

endmodule

### rtl/eul_row.sv
// ---------------------------------------------------------------------------
// eul_row
// Matrix times point: split partial products, row sums, rounding back to
// Q16.16 and saturation.
// ---------------------------------------------------------------------------
module eul_row #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  eul_pkg::t_matrix              i_coef,
    input  logic signed [COORD_WIDTH-1:0] i_vec [3],
    output logic signed [COORD_WIDTH-1:0] o_vec [3],
    output logic                          o_clip
);
    localparam int LW  = COORD_WIDTH / 2;
    localparam int HW  = COORD_WIDTH - LW;
    localparam int CW  = $bits(eul_pkg::t_coef);
    localparam int PHW = CW + HW;
    localparam int PLW = CW + LW + 1;
    localparam int TW  = CW + COORD_WIDTH + 3;
    localparam int VW  = TW - 30;
    localparam longint MAXL = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam logic signed [VW-1:0] MAXV = VW'(MAXL);
    localparam logic signed [VW-1:0] MINV = VW'(-MAXL - 1);

    // partial products, coordinate split in a signed high and unsigned low half
    logic signed [PHW-1:0] r_phi [9];
    logic signed [PLW-1:0] r_plo [9];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_phi[k] <= PHW'($signed(i_coef[k])) *
                            PHW'($signed(i_vec[k % 3][COORD_WIDTH-1:LW]));
                r_plo[k] <= PLW'($signed(i_coef[k])) *
                            $signed({{(PLW-LW){1'b0}}, i_vec[k % 3][LW-1:0]});
            end
        end
    end

    // row sums
    logic signed [TW-1:0] r_shi [3];
    logic signed [TW-1:0] r_slo [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_shi[r] <= TW'(r_phi[3*r]) + TW'(r_phi[3*r+1]) + TW'(r_phi[3*r+2]);
                r_slo[r] <= TW'(r_plo[3*r]) + TW'(r_plo[3*r+1]) + TW'(r_plo[3*r+2]);
            end
        end
    end

    // recombine and round to Q16.16
    logic signed [TW-1:0] w_tot [3];
    logic signed [VW-1:0] r_v   [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_tot[r] = (r_shi[r] <<< LW) + r_slo[r] + $signed(TW'(eul_pkg::Q_HALF));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_v[r] <= w_tot[r][TW-1:30];
            end
        end
    end

    // saturate
    logic signed [COORD_WIDTH-1:0] r_out [3];
    logic                          r_clip;
    logic signed [COORD_WIDTH-1:0] n_out [3];
    logic                          n_clip;

    always_comb begin
        n_clip = 1'b0;
        for (int r = 0; r < 3; r++) begin
            if (r_v[r] > MAXV) begin
                n_out[r] = MAXV[COORD_WIDTH-1:0];
                n_clip   = 1'b1;
            end else if (r_v[r] < MINV) begin
                n_out[r] = MINV[COORD_WIDTH-1:0];
                n_clip   = 1'b1;
            end else begin
                n_out[r] = r_v[r][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out  <= n_out;
            r_clip <= n_clip;
        end
    end

    assign o_vec  = r_out;
    assign o_clip = r_clip;

endmodule

### rtl/eul_skid.sv
// ---------------------------------------------------------------------------
// eul_skid
// Two-entry output buffer: output register plus skid register, with a
// registered room flag that holds the pipeline.
// ---------------------------------------------------------------------------
`include "euler_rotation_3d_unit_assert.svh"

module eul_skid #(
    parameter int DATA_W = 97
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_room,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);
    logic              r_out_valid;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_out;
    logic [DATA_W-1:0] r_skid;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || i_ready) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (i_ready && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `EUL_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid item without output item")
    `EUL_ASSERT_NXT(a_skid_catch, i_clk, i_rst_n, i_push && r_out_valid && !i_ready, r_skid_valid, "stalled item not caught")

endmodule

### rtl/euler_rotation_3d_unit.sv
// ---------------------------------------------------------------------------
// euler_rotation_3d_unit
// Rotates a Q16.16 point by three binary Euler angles, x-y-z or z-y-x order.
//
//   channel   dir   handshake     payload
//   i_item    in    valid/ready   action, vec_x/y/z, angle_x/y/z
//   o_item    out   valid/ready   out_x/y/z, clipped
//
// One item per cycle while the skid register has room; an accepted item
// runs through 23 sine, 3 matrix, 4 multiply-accumulate and 1 output stages.
// Reset (synchronous, active low) clears the valid pipeline and output buffer.
// The whole pipeline holds when the skid register is full; i_item.ready is a
// registered flag, so an item is still taken while a result waits at o_item.
// ---------------------------------------------------------------------------
`include "euler_rotation_3d_unit_assert.svh"

module euler_rotation_3d_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    eul_in_if.sink   i_item,
    eul_out_if.source o_item
);
    localparam int SLAT   = eul_pkg::SINE_LAT;
    localparam int DLY    = eul_pkg::SINE_LAT + eul_pkg::MATRIX_LAT;
    localparam int LAT    = DLY + eul_pkg::ROW_LAT;
    localparam int DATA_W = 3 * COORD_WIDTH + 1;
    localparam logic [31:0] QUARTER = 32'h4000_0000;

    logic w_en;
    logic w_accept;
    assign w_accept     = i_item.valid && w_en;
    assign i_item.ready = w_en;

    // valid bits alongside the data
    logic [LAT-1:0] r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[LAT-2:0], i_item.valid};
        end
    end

    // phases of the three angles
    logic [31:0] w_ph [3];
    assign w_ph[0] = {i_item.angle_x, (32 - ANGLE_WIDTH)'(0)};
    assign w_ph[1] = {i_item.angle_y, (32 - ANGLE_WIDTH)'(0)};
    assign w_ph[2] = {i_item.angle_z, (32 - ANGLE_WIDTH)'(0)};

    // sine and cosine units
    eul_pkg::t_trig w_sin [3];
    eul_pkg::t_trig w_cos [3];
    for (genvar a = 0; a < 3; a++) begin : g_trig
        eul_sine u_sin (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (w_ph[a]),
            .o_sine  (w_sin[a])
        );
        eul_sine u_cos (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (w_ph[a] + QUARTER),
            .o_sine  (w_cos[a])
        );
    end

    eul_pkg::t_trig_set w_trig;
    assign w_trig.sx = w_sin[0];
    assign w_trig.cx = w_cos[0];
    assign w_trig.sy = w_sin[1];
    assign w_trig.cy = w_cos[1];
    assign w_trig.sz = w_sin[2];
    assign w_trig.cz = w_cos[2];

    // mode and point delay lines
    logic                          r_act [SLAT];
    logic signed [COORD_WIDTH-1:0] r_pt  [DLY][3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_act[0]   <= i_item.action;
            r_pt[0][0] <= i_item.vec_x;
            r_pt[0][1] <= i_item.vec_y;
            r_pt[0][2] <= i_item.vec_z;
            for (int k = 1; k < SLAT; k++) begin
                r_act[k] <= r_act[k-1];
            end
            for (int k = 1; k < DLY; k++) begin
                r_pt[k] <= r_pt[k-1];
            end
        end
    end

    // matrix
    eul_pkg::t_matrix w_coef;
    eul_matrix u_matrix (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_action (r_act[SLAT-1]),
        .i_trig   (w_trig),
        .o_coef   (w_coef)
    );

    // matrix times point
    logic signed [COORD_WIDTH-1:0] w_res [3];
    logic                          w_clip;
    eul_row #(.COORD_WIDTH(COORD_WIDTH)) u_row (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_coef (w_coef),
        .i_vec  (r_pt[DLY-1]),
        .o_vec  (w_res),
        .o_clip (w_clip)
    );

    // output buffer
    logic              w_push;
    logic [DATA_W-1:0] w_out;
    assign w_push = w_en && r_valid[LAT-1];

    eul_skid #(.DATA_W(DATA_W)) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_res[0], w_res[1], w_res[2], w_clip}),
        .o_room  (w_en),
        .o_valid (o_item.valid),
        .o_data  (w_out),
        .i_ready (o_item.ready)
    );

    assign o_item.out_x   = w_out[DATA_W-1 -: COORD_WIDTH];
    assign o_item.out_y   = w_out[2*COORD_WIDTH -: COORD_WIDTH];
    assign o_item.out_z   = w_out[COORD_WIDTH -: COORD_WIDTH];
    assign o_item.clipped = w_out[0];

    `EUL_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_valid), "pipeline moved while held")
    `EUL_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, w_accept, r_valid[0], "accepted item not in pipeline")

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rotation unit testbench
// Streams points and Euler angles into the rotation unit, predicts every
// rotated point in fixed point and compares it with the unit's output,
// under random source gaps, sink stalls and one long sink hold-off.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CW = 32;
    localparam int AW = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic                 action;
        logic signed [CW-1:0] vec_x;
        logic signed [CW-1:0] vec_y;
        logic signed [CW-1:0] vec_z;
        logic [AW-1:0]        angle_x;
        logic [AW-1:0]        angle_y;
        logic [AW-1:0]        angle_z;
    } t_point_item;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 clipped;
    } t_rotated;

    logic i_clk;
    logic i_rst_n;

    eul_in_if  #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) in_ch ();
    eul_out_if #(.COORD_WIDTH(CW)) out_ch ();

    euler_rotation_3d_unit #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch.sink),
        .o_item  (out_ch.source)
    );

    t_point_item pending_points[$];
    t_rotated    expected_points[$];
    int          mismatch_count;
    int          cycle_count;
    bit          stim_done;
    bit          calm_phase;
    bit          hold_request;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- fixed-point trig and rotation ----------------
    function automatic longint round_q30(longint v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic longint quarter_sin(longint u);
        longint theta, t2, r, s;
        int divs[6];
        divs = '{156, 110, 72, 42, 20, 6};
        theta = round_q30(u * 64'sd1686629713);
        t2    = round_q30(theta * theta);
        r     = 64'sd1073741824;
        for (int k = 0; k < 6; k++)
            r = 64'sd1073741824 - (round_q30(t2 * r) / divs[k]);
        s = round_q30(theta * r);
        if (s > 64'sd1073741824) s = 64'sd1073741824;
        return s;
    endfunction

    function automatic longint phase_sin(logic [31:0] ph);
        logic [1:0] quad;
        longint f, s;
        quad = ph[31:30];
        f    = longint'(ph[29:0]);
        s    = quarter_sin(quad[0] ? 64'sd1073741824 - f : f);
        return quad[1] ? -s : s;
    endfunction

    function automatic longint coord_of_row(longint m[3], longint c[3], ref bit clip);
        longint hsum, lsum, hq, hr, v, h, l;
        longint maxv, minv;
        hsum = 0;
        lsum = 0;
        maxv = (64'sd1 <<< (CW - 1)) - 1;
        minv = -maxv - 1;
        for (int i = 0; i < 3; i++) begin
            h = c[i] >>> 24;
            l = c[i] & 64'hFF_FFFF;
            hsum += m[i] * h;
            lsum += m[i] * l;
        end
        hq = hsum >>> 6;
        hr = hsum - hq * 64;
        v  = hq + round_q30(hr * 64'sd16777216 + lsum);
        if (v > maxv) begin clip = 1'b1; v = maxv; end
        if (v < minv) begin clip = 1'b1; v = minv; end
        return v;
    endfunction

    function automatic t_rotated rotate_point(t_point_item it);
        logic [31:0] px, py, pz;
        longint sx, cx, sy, cy, sz, cz;
        longint m[3][3];
        longint c[3], row[3];
        longint r[3];
        bit clip;
        t_rotated res;
        px = {it.angle_x, 16'd0};
        py = {it.angle_y, 16'd0};
        pz = {it.angle_z, 16'd0};
        sx = phase_sin(px); cx = phase_sin(px + 32'h4000_0000);
        sy = phase_sin(py); cy = phase_sin(py + 32'h4000_0000);
        sz = phase_sin(pz); cz = phase_sin(pz + 32'h4000_0000);
        c[0] = it.vec_x; c[1] = it.vec_y; c[2] = it.vec_z;
        if (it.action == 1'b0) begin
            m[0][0] = round_q30(cy * cz);
            m[0][1] = -round_q30(cy * sz);
            m[0][2] = sy;
            m[1][0] = round_q30(round_q30(cz * sx) * sy) + round_q30(cx * sz);
            m[1][1] = round_q30(cx * cz) - round_q30(round_q30(sx * sy) * sz);
            m[1][2] = -round_q30(cy * sx);
            m[2][0] = -round_q30(round_q30(cx * cz) * sy) + round_q30(sx * sz);
            m[2][1] = round_q30(cz * sx) + round_q30(round_q30(cx * sy) * sz);
            m[2][2] = round_q30(cx * cy);
        end else begin
            m[0][0] = round_q30(cy * cz);
            m[0][1] = round_q30(round_q30(cz * sx) * sy) - round_q30(cx * sz);
            m[0][2] = round_q30(round_q30(cx * cz) * sy) + round_q30(sx * sz);
            m[1][0] = round_q30(cy * sz);
            m[1][1] = round_q30(cx * cz) + round_q30(round_q30(sx * sy) * sz);
            m[1][2] = -round_q30(cz * sx) + round_q30(round_q30(cx * sy) * sz);
            m[2][0] = -sy;
            m[2][1] = round_q30(cy * sx);
            m[2][2] = round_q30(cx * cy);
        end
        clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) row[j] = m[i][j];
            r[i] = coord_of_row(row, c, clip);
        end
        res.out_x   = r[0][CW-1:0];
        res.out_y   = r[1][CW-1:0];
        res.out_z   = r[2][CW-1:0];
        res.clipped = clip;
        return res;
    endfunction

    // ---------------- stimulus generation ----------------
    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1:       return 32'h8000_0000 + $urandom_range(0, 3);
            2:       return $urandom;
            3:       return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return 32'($signed(17'($urandom)) <<< 8);
        endcase
    endfunction

    function automatic logic [AW-1:0] rand_angle();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 3)) << 14;
            1:       return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 4))
                            - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_point(logic act, logic [CW-1:0] x, logic [CW-1:0] y,
                               logic [CW-1:0] z, logic [AW-1:0] ax, logic [AW-1:0] ay,
                               logic [AW-1:0] az);
        t_point_item it;
        it = '{act, x, y, z, ax, ay, az};
        pending_points.push_back(it);
    endtask

    initial begin
        logic [CW-1:0] corners[4];
        logic [AW-1:0] angs[6];
        corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_0000};
        angs    = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
        // directed: identity, axis angles, extremes, saturation in both modes
        for (int m = 0; m < 2; m++) begin
            queue_point(m[0], 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
            for (int a = 1; a < 6; a++)
                queue_point(m[0], corners[a % 4], corners[(a + 1) % 4],
                            corners[(a + 2) % 4], angs[a], angs[(a + 2) % 6],
                            angs[(a + 4) % 6]);
            queue_point(m[0], 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        16'h2000, 16'h2000, 16'h2000);
            queue_point(m[0], 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        16'hE000, 16'h6000, 16'hA000);
            queue_point(m[0], 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                        16'hFFFF, 16'h5555, 16'hAAAA);
        end
        // random
        for (int n = 0; n < 1930; n++)
            queue_point($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(),
                        rand_angle(), rand_angle(), rand_angle());
    end

    // ---------------- reset and run control ----------------
    initial begin
        int quiet;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stim_done && expected_points.size() == 0);
        quiet = 0;
        while (quiet < DRAIN_CYCLES) begin
            @(posedge i_clk);
            quiet++;
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- driver ----------------
    int src_gap;
    bit in_taken;
    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.vec_x = '0; in_ch.vec_y = '0; in_ch.vec_z = '0;
        in_ch.angle_x = '0; in_ch.angle_y = '0; in_ch.angle_z = '0;
        out_ch.ready = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        src_gap = 0;
        stim_done = 1'b0;
        calm_phase = 1'b0;
        hold_request = 1'b0;
    end

    // handshake as seen at the rising edge; ready may move right after it
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
    end

    always @(negedge i_clk) begin
        t_point_item it;
        if (i_rst_n) begin
            // the item on the bus was taken at the last rising edge
            if (in_taken)
                void'(pending_points.pop_front());
            calm_phase <= (pending_points.size() < 250);
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_points.size() == 0) begin
                in_ch.valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (!calm_phase && !(in_ch.valid && !in_taken)
                         && $urandom_range(0, 15) == 0) begin
                src_gap <= $urandom_range(0, 9);
                in_ch.valid <= 1'b0;
            end else begin
                it = pending_points[0];
                in_ch.valid   <= 1'b1;
                in_ch.action  <= it.action;
                in_ch.vec_x   <= it.vec_x;
                in_ch.vec_y   <= it.vec_y;
                in_ch.vec_z   <= it.vec_z;
                in_ch.angle_x <= it.angle_x;
                in_ch.angle_y <= it.angle_y;
                in_ch.angle_z <= it.angle_z;
            end
        end
    end

    // long sink hold-off, counted in its own process
    initial begin
        int held;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_request = 1'b1;
        held = 0;
        while (held < 200) begin
            @(posedge i_clk);
            held++;
        end
        hold_request = 1'b0;
    end

    // sink stalls
    int sink_gap;
    initial sink_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_request) begin
                out_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 12) == 0) begin
                sink_gap <= $urandom_range(0, 9);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_point_item it;
        t_rotated got, want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                it = '{in_ch.action, in_ch.vec_x, in_ch.vec_y, in_ch.vec_z,
                       in_ch.angle_x, in_ch.angle_y, in_ch.angle_z};
                expected_points.push_back(rotate_point(it));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.clipped};
                if (expected_points.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result x=%h y=%h z=%h clip=%b",
                                 got.out_x, got.out_y, got.out_z, got.clipped);
                end else begin
                    want = expected_points.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("exp %h %h %h c=%b, got %h %h %h c=%b",
                                     want.out_x, want.out_y, want.out_z, want.clipped,
                                     got.out_x, got.out_y, got.out_z, got.clipped);
                    end
                end
            end
        end
    end

endmodule
